[sv/sphere_collision_test_unit_defines.svh]
// Assertion macros used by the checker file of the sphere collision test unit.
`ifndef SPHERE_COLLISION_TEST_UNIT_DEFINES_SVH
`define SPHERE_COLLISION_TEST_UNIT_DEFINES_SVH

// Implication checked on the same clock edge.
`define SCOL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scol assertion failed");

// A signal holds its value while a beat is offered and not taken.
`define SCOL_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy)) |=> $stable(sig)) \
        else $error("scol stalled beat changed");

`endif

[sv/scol_pkg.sv]
// Package with widths, request codes and stage payload types of the sphere collision test unit.
package scol_pkg;

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int MAG_W    = 32;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int AXIS_W   = SQ_W + 1;
    localparam int SUM_W    = SQ_W + 3;
    localparam int NUM_AXES = 3;

    typedef enum logic {
        REQ_SPHERE = 1'b0,
        REQ_BOX    = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic                              is_box;
        logic [NUM_AXES-1:0][MAG_W-1:0]    mag_a;
        logic [NUM_AXES-1:0][MAG_W-1:0]    mag_b;
        logic [MAG_W-1:0]                  bound_mag;
    } diff_t;

    typedef struct packed {
        logic                              is_box;
        logic [NUM_AXES-1:0][SQ_W-1:0]     sq_a;
        logic [NUM_AXES-1:0][SQ_W-1:0]     sq_b;
        logic [SQ_W-1:0]                   bound_sq;
    } square_t;

endpackage

[sv/scol_if.sv]
// Request and result channel interfaces of the sphere collision test unit.
interface scol_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic signed [scol_pkg::COORD_W-1:0]  center_x;
    logic signed [scol_pkg::COORD_W-1:0]  center_y;
    logic signed [scol_pkg::COORD_W-1:0]  center_z;
    logic        [scol_pkg::RAD_W-1:0]    radius;
    logic signed [scol_pkg::COORD_W-1:0]  near_x;
    logic signed [scol_pkg::COORD_W-1:0]  near_y;
    logic signed [scol_pkg::COORD_W-1:0]  near_z;
    logic signed [scol_pkg::COORD_W-1:0]  far_x;
    logic signed [scol_pkg::COORD_W-1:0]  far_y;
    logic signed [scol_pkg::COORD_W-1:0]  far_z;
    logic        [scol_pkg::RAD_W-1:0]    other_radius;

    modport source (
        output valid, req_type, center_x, center_y, center_z, radius,
               near_x, near_y, near_z, far_x, far_y, far_z, other_radius,
        input  ready
    );
    modport sink (
        input  valid, req_type, center_x, center_y, center_z, radius,
               near_x, near_y, near_z, far_x, far_y, far_z, other_radius,
        output ready
    );
endinterface

interface scol_res_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

[sv/scol_diff.sv]
// First stage: per-axis distance magnitudes and the radius bound.
module scol_diff (
    input  logic                 clk,
    input  logic                 rst_n,
    scol_req_if.sink             req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scol_pkg::diff_t      out_data
);

    logic                                                      valid_reg;
    scol_pkg::diff_t                                           data_reg;
    scol_pkg::diff_t                                           data_next;
    logic [scol_pkg::NUM_AXES-1:0][scol_pkg::COORD_W-1:0]      c;
    logic [scol_pkg::NUM_AXES-1:0][scol_pkg::COORD_W-1:0]      n;
    logic [scol_pkg::NUM_AXES-1:0][scol_pkg::COORD_W-1:0]      f;
    logic [scol_pkg::NUM_AXES-1:0][scol_pkg::COORD_W:0]        d_cn;
    logic [scol_pkg::NUM_AXES-1:0][scol_pkg::COORD_W:0]        d_cf;
    logic [scol_pkg::NUM_AXES-1:0][scol_pkg::COORD_W:0]        d_cn_abs;
    logic                                                      is_box;
    logic                                                      load;

    assign c = {req.center_z, req.center_y, req.center_x};
    assign n = {req.near_z, req.near_y, req.near_x};
    assign f = {req.far_z, req.far_y, req.far_x};
    assign is_box = (req.req_type == scol_pkg::REQ_BOX);

    always_comb
    begin
        data_next.is_box = is_box;
        for (int i = 0; i < scol_pkg::NUM_AXES; i++)
        begin
            d_cn[i] = {c[i][scol_pkg::COORD_W-1], c[i]} - {n[i][scol_pkg::COORD_W-1], n[i]};
            d_cf[i] = {c[i][scol_pkg::COORD_W-1], c[i]} - {f[i][scol_pkg::COORD_W-1], f[i]};
            d_cn_abs[i] = d_cn[i][scol_pkg::COORD_W] ? (~d_cn[i] + 1'b1) : d_cn[i];
            if (is_box)
            begin
                data_next.mag_a[i] = d_cn[i][scol_pkg::COORD_W] ?
                                     d_cn_abs[i][scol_pkg::MAG_W-1:0] : '0;
                data_next.mag_b[i] = (!d_cf[i][scol_pkg::COORD_W] && (d_cf[i] != '0)) ?
                                     d_cf[i][scol_pkg::MAG_W-1:0] : '0;
            end
            else
            begin
                data_next.mag_a[i] = d_cn_abs[i][scol_pkg::MAG_W-1:0];
                data_next.mag_b[i] = '0;
            end
        end
        if (is_box)
        begin
            data_next.bound_mag = scol_pkg::MAG_W'(req.radius);
        end
        else
        begin
            data_next.bound_mag = scol_pkg::MAG_W'(req.radius) + scol_pkg::MAG_W'(req.other_radius);
        end
    end

    assign req.ready = !valid_reg || out_ready;
    assign load      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/scol_square.sv]
// Second stage: squares of the distance magnitudes and of the radius bound.
module scol_square (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  scol_pkg::diff_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scol_pkg::square_t    out_data
);

    logic                 valid_reg;
    scol_pkg::square_t    data_reg;
    scol_pkg::square_t    data_next;

    always_comb
    begin
        data_next.is_box = in_data.is_box;
        for (int i = 0; i < scol_pkg::NUM_AXES; i++)
        begin
            data_next.sq_a[i] = scol_pkg::SQ_W'(in_data.mag_a[i]) * scol_pkg::SQ_W'(in_data.mag_a[i]);
            data_next.sq_b[i] = scol_pkg::SQ_W'(in_data.mag_b[i]) * scol_pkg::SQ_W'(in_data.mag_b[i]);
        end
        data_next.bound_sq = scol_pkg::SQ_W'(in_data.bound_mag) * scol_pkg::SQ_W'(in_data.bound_mag);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/scol_reduce.sv]
// Last three stages: per-axis sums, the total sum and the final compare into the result register.
module scol_reduce (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  scol_pkg::square_t    in_data,
    scol_res_if.source           res
);

    typedef struct packed {
        logic                                                  is_box;
        logic [scol_pkg::NUM_AXES-1:0][scol_pkg::AXIS_W-1:0]   axis_sum;
        logic [scol_pkg::SQ_W-1:0]                             bound_sq;
    } axis_stage_t;

    typedef struct packed {
        logic                          is_box;
        logic [scol_pkg::SUM_W-1:0]    total;
        logic [scol_pkg::SQ_W-1:0]     bound_sq;
    } total_stage_t;

    logic            a_valid_reg;
    logic            b_valid_reg;
    logic            c_valid_reg;
    logic            a_ready;
    logic            b_ready;
    logic            c_ready;
    axis_stage_t     a_reg;
    axis_stage_t     a_next;
    total_stage_t    b_reg;
    total_stage_t    b_next;
    logic            hit_reg;
    logic            hit_next;
    logic [scol_pkg::SUM_W-1:0] bound_ext;

    assign c_ready  = !c_valid_reg || res.ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        a_next.is_box   = in_data.is_box;
        a_next.bound_sq = in_data.bound_sq;
        for (int i = 0; i < scol_pkg::NUM_AXES; i++)
        begin
            a_next.axis_sum[i] = scol_pkg::AXIS_W'(in_data.sq_a[i]) +
                                 scol_pkg::AXIS_W'(in_data.sq_b[i]);
        end
    end

    always_comb
    begin
        b_next.is_box   = a_reg.is_box;
        b_next.bound_sq = a_reg.bound_sq;
        b_next.total    = scol_pkg::SUM_W'(a_reg.axis_sum[0]) +
                          scol_pkg::SUM_W'(a_reg.axis_sum[1]) +
                          scol_pkg::SUM_W'(a_reg.axis_sum[2]);
    end

    assign bound_ext = scol_pkg::SUM_W'(b_reg.bound_sq);

    // Touching spheres do not hit; a touching box does.
    always_comb
    begin
        if (b_reg.is_box)
        begin
            hit_next = (b_reg.total <= bound_ext);
        end
        else
        begin
            hit_next = (b_reg.total < bound_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_reg <= a_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_reg <= b_next;
        end
        if (b_valid_reg && c_ready)
        begin
            hit_reg <= hit_next;
        end
    end

    assign res.valid = c_valid_reg;
    assign res.hit   = hit_reg;

endmodule

[sv/sphere_collision_test_unit.sv]
// Top level of the sphere collision test unit: five-stage sphere/sphere and sphere/box tester.
// Takes one request beat per clock while the result side does not stall, and returns one
// hit beat per request, in order. The five register stages are: distance magnitudes,
// squaring (seven 32 by 32 multipliers), per-axis sums, the total sum, and the compare
// against the squared radius bound, whose register drives the result channel. Each stage
// takes a new beat as soon as its own beat moves on, so a stall at the result side fills
// the pipeline before the request side stops, and bubbles close up.
module sphere_collision_test_unit (
    input  logic         clk,
    input  logic         rst_n,
    scol_req_if.sink     req,
    scol_res_if.source   res
);

    logic                 diff_valid;
    logic                 diff_ready;
    scol_pkg::diff_t      diff_data;
    logic                 sq_valid;
    logic                 sq_ready;
    scol_pkg::square_t    sq_data;

    scol_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_data  (diff_data)
    );

    scol_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_data   (diff_data),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    scol_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_valid),
        .in_ready (sq_ready),
        .in_data  (sq_data),
        .res      (res)
    );

endmodule

[sv/scol_checker.sv]
// Port-level checker of the sphere collision test unit and its bind.
`include "sphere_collision_test_unit_defines.svh"

module scol_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_hit
);

    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       req_beat;
    logic       res_beat;

    assign req_beat = req_valid && req_ready;
    assign res_beat = res_valid && res_ready;

    always_comb
    begin
        count_next = count_reg + {2'b00, req_beat} - {2'b00, res_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `SCOL_ASSERT_HOLD(a_res_valid_hold, res_valid, res_ready, res_valid)
    `SCOL_ASSERT_HOLD(a_res_hit_hold, res_valid, res_ready, res_hit)
    `SCOL_ASSERT_NOW(a_res_needs_req, res_valid, count_reg != 3'd0)
    `SCOL_ASSERT_NOW(a_empty_is_ready, count_reg == 3'd0, req_ready)

endmodule

bind sphere_collision_test_unit scol_checker u_scol_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_hit   (res.hit)
);

[bench/sphere_collision_checker.sv]
// Checker that predicts every hit beat of the sphere collision test unit and compares it.
`timescale 1ns / 1ps

module sphere_collision_checker
    import scol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    scol_req_if         req,
    scol_res_if         res,
    output int          hit_errors,
    output int          hits_pending
);

    bit expected_hits[$];
    int result_index;

    function automatic bit shapes_intersect(
        input req_kind_t                       kind,
        input logic [NUM_AXES-1:0][COORD_W-1:0] ctr,
        input logic [RAD_W-1:0]                rad,
        input logic [NUM_AXES-1:0][COORD_W-1:0] lo,
        input logic [NUM_AXES-1:0][COORD_W-1:0] hi,
        input logic [RAD_W-1:0]                rad2
    );
        logic signed [COORD_W:0] c;
        logic signed [COORD_W:0] a;
        logic signed [COORD_W:0] b;
        logic signed [COORD_W:0] d;
        logic [MAG_W-1:0]        m;
        logic [SUM_W:0]          total;
        logic [MAG_W-1:0]        rsum;
        logic [SQ_W-1:0]         bound;
        total = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            c = {ctr[i][COORD_W-1], ctr[i]};
            a = {lo[i][COORD_W-1], lo[i]};
            b = {hi[i][COORD_W-1], hi[i]};
            if (kind == REQ_SPHERE)
            begin
                d = c - a;
                m = d[COORD_W] ? 32'(-d) : d[MAG_W-1:0];
                total = total + (SUM_W+1)'(64'(m) * 64'(m));
            end
            else
            begin
                if (c < a)
                begin
                    m = 32'(a - c);
                    total = total + (SUM_W+1)'(64'(m) * 64'(m));
                end
                if (c > b)
                begin
                    m = 32'(c - b);
                    total = total + (SUM_W+1)'(64'(m) * 64'(m));
                end
            end
        end
        if (kind == REQ_SPHERE)
        begin
            rsum = 32'(rad) + 32'(rad2);
            bound = 64'(rsum) * 64'(rsum);
            return total < (SUM_W+1)'(bound);
        end
        bound = 64'(rad) * 64'(rad);
        return total <= (SUM_W+1)'(bound);
    endfunction

    assign hits_pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_hits.delete();
            hit_errors   <= 0;
            result_index <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                result_index <= result_index + 1;
                if (expected_hits.size() == 0)
                begin
                    if (hit_errors < 10)
                        $display("Result beat %0d arrived with no request waiting, hit=%0b",
                                 result_index, res.hit);
                    hit_errors <= hit_errors + 1;
                end
                else
                begin
                    if (res.hit !== expected_hits[0])
                    begin
                        if (hit_errors < 10)
                            $display("Result beat %0d: expected hit=%0b, got hit=%0b",
                                     result_index, expected_hits[0], res.hit);
                        hit_errors <= hit_errors + 1;
                    end
                    void'(expected_hits.pop_front());
                end
            end
            if (req.valid && req.ready)
                expected_hits.push_back(shapes_intersect(
                    req_kind_t'(req.req_type),
                    {req.center_z, req.center_y, req.center_x},
                    req.radius,
                    {req.near_z, req.near_y, req.near_x},
                    {req.far_z, req.far_y, req.far_x},
                    req.other_radius));
        end
    end

endmodule

[bench/testbench.sv]
// Top of the sphere collision test unit bench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module testbench;
    import scol_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MIN   = 32'h8000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX   = 32'h7fff_ffff;
    localparam logic [RAD_W-1:0]   RAD_MAX     = 31'h7fff_ffff;
    localparam int                 CYCLE_LIMIT = 200000;
    localparam int                 PHASE_ITEMS = 400;

    typedef struct {
        req_kind_t                        kind;
        logic [NUM_AXES-1:0][COORD_W-1:0] ctr;
        logic [RAD_W-1:0]                 rad;
        logic [NUM_AXES-1:0][COORD_W-1:0] lo;
        logic [NUM_AXES-1:0][COORD_W-1:0] hi;
        logic [RAD_W-1:0]                 rad2;
    } query_t;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   hit_errors;
    int   hits_pending;
    int   cycle_count;

    scol_req_if req_ch();
    scol_res_if res_ch();

    sphere_collision_test_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    sphere_collision_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .hit_errors   (hit_errors),
        .hits_pending (hits_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic query_t make_query(
        input req_kind_t        kind,
        input logic [31:0]      cx, cy, cz,
        input logic [RAD_W-1:0] r,
        input logic [31:0]      nx, ny, nz, fx, fy, fz,
        input logic [RAD_W-1:0] r2
    );
        query_t q;
        q.kind = kind;
        q.ctr  = {cz, cy, cx};
        q.rad  = r;
        q.lo   = {nz, ny, nx};
        q.hi   = {fz, fy, fx};
        q.rad2 = r2;
        return q;
    endfunction

    function automatic query_t random_query();
        query_t      q;
        int          mode;
        int          ax;
        int          ax2;
        int          base;
        int          k;
        logic [31:0] d;
        logic [31:0] w;
        q.kind = req_kind_t'($urandom_range(0, 1));
        for (int i = 0; i < NUM_AXES; i++)
        begin
            q.ctr[i] = $urandom;
            q.lo[i]  = $urandom;
            q.hi[i]  = $urandom;
        end
        q.rad  = RAD_W'($urandom);
        q.rad2 = RAD_W'($urandom);
        mode = $urandom_range(0, 9);
        ax   = $urandom_range(0, 2);
        ax2  = (ax + 1) % NUM_AXES;
        k    = $urandom_range(0, 1 << 26);
        if (mode >= 3 && mode <= 5)
        begin
            base = $urandom;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                q.ctr[i] = base + $urandom_range(0, 8192) - 4096;
                q.lo[i]  = base + $urandom_range(0, 8192) - 4096;
                w = $urandom_range(0, 4096);
                q.hi[i]  = ($urandom_range(0, 7) == 0) ? q.lo[i] - w : q.lo[i] + w;
            end
            q.rad  = RAD_W'($urandom_range(0, 4096));
            q.rad2 = RAD_W'($urandom_range(0, 4096));
        end
        else if (mode >= 6 && mode <= 7)
        begin
            q.kind = REQ_SPHERE;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                base = int'($urandom_range(0, 1 << 30)) - (1 << 29);
                q.ctr[i] = base;
                q.lo[i]  = base;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                d = $urandom_range(0, 1 << 30);
                q.lo[ax] = ($urandom_range(0, 1) == 0) ? q.ctr[ax] + d : q.ctr[ax] - d;
            end
            else
            begin
                d = 5 * k;
                q.lo[ax]  = q.ctr[ax] + 3 * k;
                q.lo[ax2] = q.ctr[ax2] - 4 * k;
            end
            q.rad  = RAD_W'($urandom_range(0, d));
            q.rad2 = RAD_W'(d) - q.rad;
            case ($urandom_range(0, 2))
                1: q.rad2 = q.rad2 + 1'b1;
                2: if (q.rad2 != 0) q.rad2 = q.rad2 - 1'b1;
                default: ;
            endcase
        end
        else if (mode >= 8)
        begin
            q.kind = REQ_BOX;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                base = int'($urandom_range(0, 1 << 30)) - (1 << 29);
                w = $urandom_range(0, 1 << 20);
                q.lo[i]  = base;
                q.hi[i]  = base + w;
                q.ctr[i] = base + $urandom_range(0, w);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << 28);
                q.ctr[ax] = ($urandom_range(0, 1) == 0) ? q.lo[ax] - d : q.hi[ax] + d;
            end
            else
            begin
                d = 5 * k;
                q.ctr[ax]  = q.lo[ax] - 3 * k;
                q.ctr[ax2] = q.hi[ax2] + 4 * k;
            end
            q.rad = RAD_W'(d);
            case ($urandom_range(0, 2))
                1: q.rad = q.rad + 1'b1;
                2: if (q.rad != 0) q.rad = q.rad - 1'b1;
                default: ;
            endcase
        end
        return q;
    endfunction

    task automatic send_query(input query_t q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.req_type     <= q.kind;
        req_ch.center_x     <= q.ctr[0];
        req_ch.center_y     <= q.ctr[1];
        req_ch.center_z     <= q.ctr[2];
        req_ch.radius       <= q.rad;
        req_ch.near_x       <= q.lo[0];
        req_ch.near_y       <= q.lo[1];
        req_ch.near_z       <= q.lo[2];
        req_ch.far_x        <= q.hi[0];
        req_ch.far_y        <= q.hi[1];
        req_ch.far_z        <= q.hi[2];
        req_ch.other_radius <= q.rad2;
        req_ch.valid        <= 1'b1;
        @(posedge clk iff req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (hits_pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk iff res_ch.valid);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        query_t directed[$];
        rst_n               <= 1'b0;
        no_idle             = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_SPHERE;
        req_ch.center_x     <= '0;
        req_ch.center_y     <= '0;
        req_ch.center_z     <= '0;
        req_ch.radius       <= '0;
        req_ch.near_x       <= '0;
        req_ch.near_y       <= '0;
        req_ch.near_z       <= '0;
        req_ch.far_x        <= '0;
        req_ch.far_y        <= '0;
        req_ch.far_z        <= '0;
        req_ch.other_radius <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_query(REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_query(REQ_SPHERE, 0, 0, 0, 1, 0, 0, 0,
                                      COORD_MAX, COORD_MIN, COORD_MAX, 0));
        // Spheres that touch exactly do not count as a hit.
        directed.push_back(make_query(REQ_SPHERE, 0, 0, 0, 2, 3, 4, 0,
                                      COORD_MIN, COORD_MIN, COORD_MIN, 3));
        directed.push_back(make_query(REQ_SPHERE, 0, 0, 0, 2, 3, 4, 0, 0, 0, 0, 4));
        directed.push_back(make_query(REQ_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, RAD_MAX));
        directed.push_back(make_query(REQ_SPHERE, COORD_MIN, 0, 0, RAD_MAX,
                                      COORD_MAX, 0, 0, 0, 0, 0, RAD_MAX));
        directed.push_back(make_query(REQ_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX));
        directed.push_back(make_query(REQ_SPHERE, -100, 50, 7, 0, -100, 50, 7, 0, 0, 0, 0));
        // Box cases: inside, on a face, just outside, touching at the radius.
        directed.push_back(make_query(REQ_BOX, 5, 5, 5, 0, 0, 0, 0, 10, 10, 10, RAD_MAX));
        directed.push_back(make_query(REQ_BOX, 10, 0, 5, 0, 0, 0, 0, 10, 10, 10, 0));
        directed.push_back(make_query(REQ_BOX, 11, 5, 5, 0, 0, 0, 0, 10, 10, 10, 0));
        directed.push_back(make_query(REQ_BOX, -5, 5, 5, 5, 0, 0, 0, 10, 10, 10, 0));
        directed.push_back(make_query(REQ_BOX, -5, 5, 5, 4, 0, 0, 0, 10, 10, 10, 0));
        directed.push_back(make_query(REQ_BOX, -3, 14, 5, 5, 0, 0, 0, 10, 10, 10, 0));
        // An inverted box adds the excess on both sides of the axis.
        directed.push_back(make_query(REQ_BOX, 0, 0, 0, 14, 10, 0, 0, -10, 0, 0, 0));
        directed.push_back(make_query(REQ_BOX, 0, 0, 0, 15, 10, 0, 0, -10, 0, 0, 0));
        directed.push_back(make_query(REQ_BOX, 0, 0, 0, RAD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX));
        directed.push_back(make_query(REQ_BOX, COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX, 0));
        directed.push_back(make_query(REQ_BOX, 1234, -99, COORD_MAX, 0,
                                      COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX));
        directed.push_back(make_query(REQ_BOX, COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX,
                                      COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MIN, COORD_MIN, COORD_MIN, 0));
        foreach (directed[i])
            send_query(directed[i]);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            no_idle = (phase == 2);
            repeat (PHASE_ITEMS) send_query(random_query());
            drain_results();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge clk);
        if (hit_errors == 0 && hits_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sphere_collision_test_unit.f]
+incdir+sv
sv/scol_pkg.sv
sv/scol_if.sv
sv/scol_diff.sv
sv/scol_square.sv
sv/scol_reduce.sv
sv/sphere_collision_test_unit.sv
sv/scol_checker.sv
bench/sphere_collision_checker.sv
bench/testbench.sv
